/* rtl/pwt_pkg.sv */
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types, codes and fixed-point helpers of the PID controller with
// twiddle gain tuning.
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

	// item kinds
	localparam logic [1:0] KIND_RUN     = 2'd0;
	localparam logic [1:0] KIND_TUNE    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_CLEAR   = 2'd3;

	// tuning phases
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_P_UPD   = 4'd1;
	localparam logic [3:0] PH_P_CHK1  = 4'd2;
	localparam logic [3:0] PH_P_CHK2  = 4'd3;
	localparam logic [3:0] PH_I_UPD   = 4'd4;
	localparam logic [3:0] PH_I_CHK1  = 4'd5;
	localparam logic [3:0] PH_I_CHK2  = 4'd6;
	localparam logic [3:0] PH_D_UPD   = 4'd7;
	localparam logic [3:0] PH_D_CHK1  = 4'd8;
	localparam logic [3:0] PH_D_CHK2  = 4'd9;
	localparam logic [3:0] PH_TRAINED = 4'd10;

	// configuration register indexes
	localparam logic [2:0] REG_START_KP    = 3'd0;
	localparam logic [2:0] REG_START_KI    = 3'd1;
	localparam logic [2:0] REG_START_KD    = 3'd2;
	localparam logic [2:0] REG_START_PHASE = 3'd3;
	localparam logic [2:0] REG_TUNE_TOL    = 3'd4;

	// Q16.16 constants
	localparam logic signed [31:0] Q_ONE     = 32'sd65536;
	localparam logic signed [31:0] BEST_INIT = 32'sd65536000;
	localparam logic signed [17:0] GROW_Q    = 18'sd72090;
	localparam logic signed [17:0] SHRINK_Q  = 18'sd58982;
	localparam logic [30:0]        TOL_RESET = 31'd13107;

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	typedef struct packed {
		logic signed [31:0] start_kp;
		logic signed [31:0] start_ki;
		logic signed [31:0] start_kd;
		logic [3:0]         start_phase;
		logic [30:0]        tune_tol;
	} cfg_t;

	typedef struct packed {
		logic               fire;
		logic [1:0]         kind;
		logic signed [15:0] sample;
	} op_t;

	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] i;
		logic signed [31:0] d;
	} gains_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > SAT_HI) begin
			return 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// step * k rounded half up to Q16.16, saturated
	function automatic logic signed [31:0] scale_step(input logic signed [31:0] s,
	                                                   input logic signed [17:0] k);
		logic signed [49:0] prod;
		prod = 50'(s) * 50'(k);
		return sat32(66'((prod + 50'sd32768) >>> 16));
	endfunction

endpackage

`default_nettype wire

/* rtl/pwt_pid_calc.sv */
// ----------------------------------------------------------------------------
// pwt_pid_calc
// Control history (previous sample, saturating integrator) and the PID
// steer computation for run words.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_pid_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  pwt_pkg::op_t       op,
	input  pwt_pkg::gains_t    gains,
	output logic signed [31:0] steer_nxt
);
	import pwt_pkg::*;

	logic signed [15:0] last_q;
	logic signed [31:0] sum_q;

	logic signed [16:0] diff;
	logic signed [31:0] sum_nxt;
	logic signed [47:0] prod_p;
	logic signed [48:0] prod_d;
	logic signed [63:0] prod_i;
	logic signed [39:0] term_p;
	logic signed [40:0] term_d;
	logic signed [55:0] term_i;
	logic signed [57:0] acc;
	logic signed [58:0] neg;

	always_comb begin
		diff    = 17'(op.sample) - 17'(last_q);
		sum_nxt = sat32(66'(33'(sum_q) + 33'(op.sample)));
		prod_p  = 48'(gains.p) * 48'(op.sample);
		prod_d  = 49'(gains.d) * 49'(diff);
		prod_i  = 64'(gains.i) * 64'(sum_nxt);
		term_p  = 40'((prod_p + 48'sd128) >>> 8);
		term_d  = 41'((prod_d + 49'sd128) >>> 8);
		term_i  = 56'((prod_i + 64'sd128) >>> 8);
		acc     = 58'(term_p) + 58'(term_d) + 58'(term_i);
		neg     = -59'(acc);
		steer_nxt = (op.kind == KIND_RUN) ? sat32(66'(neg)) : 32'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			sum_q  <= '0;
		end else if (op.fire) begin
			case (op.kind)
				KIND_RUN: begin
					last_q <= op.sample;
					sum_q  <= sum_nxt;
				end
				KIND_RESTART, KIND_CLEAR: begin
					last_q <= '0;
					sum_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/pwt_twiddle.sv */
// ----------------------------------------------------------------------------
// pwt_twiddle
// Gain, step-size and best-error registers with the twiddle tuner. Each
// tune word performs at most one twiddle step of the phase machine.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_twiddle (
	input  logic            clk,
	input  logic            arst_n,
	input  pwt_pkg::op_t    op,
	input  pwt_pkg::cfg_t   cfg,
	output pwt_pkg::gains_t gains,
	output logic [3:0]      phase_nxt
);
	import pwt_pkg::*;

	localparam logic [1:0] SEL_P = 2'd0;
	localparam logic [1:0] SEL_I = 2'd1;
	localparam logic [1:0] SEL_D = 2'd2;

	localparam logic [1:0] SUB_NONE = 2'd0;
	localparam logic [1:0] SUB_UPD  = 2'd1;
	localparam logic [1:0] SUB_CHK1 = 2'd2;
	localparam logic [1:0] SUB_CHK2 = 2'd3;

	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [31:0] step_p_q, step_i_q, step_d_q;
	logic signed [31:0] best_q;
	logic [3:0]         phase_q;

	logic signed [33:0] total;
	logic               lock;
	logic               tune_act;
	logic signed [31:0] e32;
	logic [1:0]         sel;
	logic [1:0]         sub;
	logic [3:0]         upd_next;
	logic signed [31:0] gsel, ssel;
	logic               improve;
	logic signed [31:0] scaled;
	logic signed [31:0] g_n, s_n, best_n;
	logic [3:0]         ph_n;

	always_comb begin
		total    = 34'(step_p_q) + 34'(step_i_q) + 34'(step_d_q);
		lock     = (phase_q == PH_TRAINED) || (total <= $signed({3'b000, cfg.tune_tol}));
		tune_act = op.fire && (op.kind == KIND_TUNE);
		e32      = {{8{op.sample[15]}}, op.sample, 8'h00};

		case (phase_q)
			PH_P_UPD:  begin sel = SEL_P; sub = SUB_UPD;  upd_next = PH_I_UPD; end
			PH_P_CHK1: begin sel = SEL_P; sub = SUB_CHK1; upd_next = PH_I_UPD; end
			PH_P_CHK2: begin sel = SEL_P; sub = SUB_CHK2; upd_next = PH_I_UPD; end
			PH_I_UPD:  begin sel = SEL_I; sub = SUB_UPD;  upd_next = PH_D_UPD; end
			PH_I_CHK1: begin sel = SEL_I; sub = SUB_CHK1; upd_next = PH_D_UPD; end
			PH_I_CHK2: begin sel = SEL_I; sub = SUB_CHK2; upd_next = PH_D_UPD; end
			PH_D_UPD:  begin sel = SEL_D; sub = SUB_UPD;  upd_next = PH_P_UPD; end
			PH_D_CHK1: begin sel = SEL_D; sub = SUB_CHK1; upd_next = PH_P_UPD; end
			PH_D_CHK2: begin sel = SEL_D; sub = SUB_CHK2; upd_next = PH_P_UPD; end
			default:   begin sel = SEL_P; sub = SUB_NONE; upd_next = phase_q;  end
		endcase

		case (sel)
			SEL_I:   begin gsel = gain_i_q; ssel = step_i_q; end
			SEL_D:   begin gsel = gain_d_q; ssel = step_d_q; end
			default: begin gsel = gain_p_q; ssel = step_p_q; end
		endcase

		improve = e32 < best_q;
		scaled  = scale_step(ssel, improve ? GROW_Q : SHRINK_Q);

		g_n    = gsel;
		s_n    = ssel;
		best_n = best_q;
		ph_n   = phase_q;
		if (lock) begin
			ph_n = PH_TRAINED;
		end else begin
			case (sub)
				SUB_UPD: begin
					g_n  = sat32(66'(gsel) + 66'(ssel));
					ph_n = phase_q + 4'd1;
				end
				SUB_CHK1: begin
					if (improve) begin
						best_n = e32;
						s_n    = scaled;
						ph_n   = upd_next;
					end else begin
						g_n  = sat32(66'(gsel) - 66'(ssel) - 66'(ssel));
						ph_n = phase_q + 4'd1;
					end
				end
				SUB_CHK2: begin
					if (improve) begin
						best_n = e32;
					end else begin
						g_n = sat32(66'(gsel) + 66'(ssel));
					end
					s_n  = scaled;
					ph_n = upd_next;
				end
				default: begin
				end
			endcase
		end

		if (op.kind == KIND_RESTART) begin
			phase_nxt = cfg.start_phase;
		end else if (tune_act) begin
			phase_nxt = ph_n;
		end else begin
			phase_nxt = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			step_p_q <= Q_ONE;
			step_i_q <= Q_ONE;
			step_d_q <= Q_ONE;
			best_q   <= BEST_INIT;
			phase_q  <= PH_IDLE;
		end else if (op.fire) begin
			phase_q <= phase_nxt;
			if (op.kind == KIND_RESTART) begin
				gain_p_q <= cfg.start_kp;
				gain_i_q <= cfg.start_ki;
				gain_d_q <= cfg.start_kd;
				step_p_q <= Q_ONE;
				step_i_q <= Q_ONE;
				step_d_q <= Q_ONE;
				best_q   <= BEST_INIT;
			end else if (tune_act && !lock) begin
				best_q <= best_n;
				case (sel)
					SEL_I: begin
						gain_i_q <= g_n;
						step_i_q <= s_n;
					end
					SEL_D: begin
						gain_d_q <= g_n;
						step_d_q <= s_n;
					end
					default: begin
						gain_p_q <= g_n;
						step_p_q <= s_n;
					end
				endcase
			end
		end
	end

	assign gains = '{p: gain_p_q, i: gain_i_q, d: gain_d_q};

endmodule

`default_nettype wire

/* rtl/pid_with_twiddle_tuner_core.sv */
// ----------------------------------------------------------------------------
// pid_with_twiddle_tuner_core
// PID steering controller with an on-line twiddle gain tuner.
// Throughput: one word per cycle while out_stall does not hold the output; the
// state update of each word is made together with the result register load.
// Reset (arst_n low, asynchronous): config to defaults, gains zero, steps 1.0,
// best error 1000.0, history cleared, phase idle, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_with_twiddle_tuner_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [15:0] err_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] steer,
	output logic [3:0]         phase,
	output logic               trained
);
	import pwt_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [1:0]         kind_s1;
	logic signed [15:0] sample_s1;
	logic               out_valid_q;
	logic signed [31:0] steer_q;
	logic [3:0]         phase_q;
	logic               trained_q;

	logic               adv;
	op_t                op;
	gains_t             gains;
	logic signed [31:0] steer_nxt;
	logic [3:0]         phase_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_kp    <= '0;
			cfg_q.start_ki    <= '0;
			cfg_q.start_kd    <= '0;
			cfg_q.start_phase <= PH_IDLE;
			cfg_q.tune_tol    <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_KP:    cfg_q.start_kp    <= cfg_data;
				REG_START_KI:    cfg_q.start_ki    <= cfg_data;
				REG_START_KD:    cfg_q.start_kd    <= cfg_data;
				REG_START_PHASE: cfg_q.start_phase <= cfg_data[3:0];
				REG_TUNE_TOL:    cfg_q.tune_tol    <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			sample_s1 <= err_sample;
		end
	end

	assign op = '{fire: adv, kind: kind_s1, sample: sample_s1};

	pwt_twiddle u_twiddle (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg       (cfg_q),
		.gains     (gains),
		.phase_nxt (phase_nxt)
	);

	pwt_pid_calc u_pid (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.gains     (gains),
		.steer_nxt (steer_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			steer_q   <= steer_nxt;
			phase_q   <= phase_nxt;
			trained_q <= (phase_nxt == PH_TRAINED);
		end
	end

	assign out_valid = out_valid_q;
	assign steer     = steer_q;
	assign phase     = phase_q;
	assign trained   = trained_q;

endmodule

`default_nettype wire

/* rtl/pwt_checker.sv */
// ----------------------------------------------------------------------------
// pwt_checker
// Port-level checks of the PID twiddle core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] steer,
	input logic [3:0]         phase,
	input logic               trained
);
	import pwt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(steer) && $stable(phase))
		else $error("result word changed while stalled");

	a_trained_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (trained == (phase == PH_TRAINED)))
		else $error("trained flag disagrees with phase");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without an accepted input word");

endmodule

bind pid_with_twiddle_tuner_core pwt_checker u_pwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.steer     (steer),
	.phase     (phase),
	.trained   (trained)
);

`default_nettype wire
